[rtl/y2r_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared types and constants for the YCbCr 4:2:0 to RGB converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

  localparam int PIX_W             = 8;
  localparam int CFG_W             = 13;
  localparam int CFG_IDX_W         = 1;
  localparam int LINE_W            = 12;
  localparam int MAX_LINES         = 4096;
  localparam int DEFAULT_MAX_WIDTH = 4096;

  localparam int SUM_W  = 20;
  localparam int FRAC_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd2;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd1;

  localparam logic signed [SUM_W-1:0] LUMA_OFS   = 20'sd16;
  localparam logic signed [SUM_W-1:0] CHROMA_OFS = 20'sd128;
  localparam logic signed [SUM_W-1:0] K_Y        = 20'sd298;
  localparam logic signed [SUM_W-1:0] K_CB_B     = 20'sd516;
  localparam logic signed [SUM_W-1:0] K_CB_G     = 20'sd100;
  localparam logic signed [SUM_W-1:0] K_CR_G     = 20'sd208;
  localparam logic signed [SUM_W-1:0] K_CR_R     = 20'sd409;
  localparam logic signed [SUM_W-1:0] ROUND      = 20'sd128;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] luma_first;
    logic [PIX_W-1:0] luma_second;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] chroma_red;
    logic             line_end;
    logic             frame_end;
  } y2r_beat_t;

endpackage
`default_nettype wire

[rtl/y2r_chroma_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_chroma_store
// Raster counters, configuration registers and the chroma line memory.
// Even lines write Cb/Cr at the pair column, odd lines read it back.
// ----------------------------------------------------------------------------
module y2r_chroma_store #(
  parameter int MAX_WIDTH = y2r_pkg::DEFAULT_MAX_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [y2r_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [y2r_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [y2r_pkg::PIX_W-1:0]     in_luma_first,
  input  wire logic [y2r_pkg::PIX_W-1:0]     in_luma_second,
  input  wire logic [y2r_pkg::PIX_W-1:0]     in_chroma_blue,
  input  wire logic [y2r_pkg::PIX_W-1:0]     in_chroma_red,
  input  wire logic                          take,
  output y2r_pkg::y2r_beat_t                 beat
);
  import y2r_pkg::*;

  localparam int DEPTH  = MAX_WIDTH / 2;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CFG_W-1:0]   frame_width_r;
  logic [CFG_W-1:0]   frame_height_r;
  logic [ADDR_W-1:0]  pair_column_r;
  logic [ADDR_W-1:0]  pair_column_nxt;
  logic [LINE_W-1:0]  line_number_r;
  logic [LINE_W-1:0]  line_number_nxt;

  logic [CFG_W-1:0]   pairs;
  logic [CFG_W-1:0]   lines;
  logic [CFG_W-1:0]   col_ext;
  logic [ADDR_W-1:0]  col;
  logic               last_col;
  logic               last_line;
  logic               accept;
  logic               s1_adv;
  logic               wr_en;
  logic               rd_en;

  logic [2*PIX_W-1:0] mem [DEPTH];
  logic [2*PIX_W-1:0] rd_data_r;

  logic               s1_valid_r;
  logic [PIX_W-1:0]   luma_first_r;
  logic [PIX_W-1:0]   luma_second_r;
  logic [PIX_W-1:0]   cb_r;
  logic [PIX_W-1:0]   cr_r;
  logic               odd_r;
  logic               line_end_r;
  logic               frame_end_r;

  always_comb begin
    pairs = {1'b0, frame_width_r[CFG_W-1:1]};
    if (pairs == '0) begin
      pairs = CFG_W'(1);
    end else if (pairs > CFG_W'(DEPTH)) begin
      pairs = CFG_W'(DEPTH);
    end
    lines = frame_height_r;
    if (lines == '0) begin
      lines = CFG_W'(1);
    end else if (lines > CFG_W'(MAX_LINES)) begin
      lines = CFG_W'(MAX_LINES);
    end
    col_ext   = CFG_W'(pair_column_r);
    col       = (col_ext >= pairs) ? ADDR_W'(pairs - CFG_W'(1)) : pair_column_r;
    last_col  = (col_ext + CFG_W'(1)) >= pairs;
    last_line = (CFG_W'(line_number_r) + CFG_W'(1)) >= lines;
  end

  assign s1_adv   = !s1_valid_r || take;
  assign in_stall = !s1_adv;
  assign accept   = in_valid && s1_adv;
  assign wr_en    = accept && !line_number_r[0];
  assign rd_en    = accept && line_number_r[0];

  always_comb begin
    pair_column_nxt = pair_column_r;
    line_number_nxt = line_number_r;
    if (accept) begin
      if (last_col) begin
        pair_column_nxt = '0;
        line_number_nxt = last_line ? '0 : line_number_r + LINE_W'(1);
      end else begin
        pair_column_nxt = pair_column_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      pair_column_r  <= '0;
      line_number_r  <= '0;
      s1_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
          default: ;
        endcase
      end
      pair_column_r <= pair_column_nxt;
      line_number_r <= line_number_nxt;
      if (s1_adv) begin
        s1_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      luma_first_r  <= in_luma_first;
      luma_second_r <= in_luma_second;
      cb_r          <= in_chroma_blue;
      cr_r          <= in_chroma_red;
      odd_r         <= line_number_r[0];
      line_end_r    <= last_col;
      frame_end_r   <= last_col && last_line;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[col] <= {in_chroma_red, in_chroma_blue};
    end
    if (rd_en) begin
      rd_data_r <= mem[col];
    end
  end

  always_comb begin
    beat.valid       = s1_valid_r;
    beat.luma_first  = luma_first_r;
    beat.luma_second = luma_second_r;
    beat.chroma_blue = odd_r ? rd_data_r[PIX_W-1:0] : cb_r;
    beat.chroma_red  = odd_r ? rd_data_r[2*PIX_W-1:PIX_W] : cr_r;
    beat.line_end    = line_end_r;
    beat.frame_end   = frame_end_r;
  end

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted beat not loaded into stage 1");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_col && last_line |=> pair_column_r == '0 && line_number_r == '0)
    else $error("counters did not wrap at frame end");

  a_column_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !last_col |=>
      pair_column_r == $past(pair_column_r) + ADDR_W'(1) &&
      line_number_r == $past(line_number_r))
    else $error("pair column did not advance");

  a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !take |=> s1_valid_r && $stable(luma_first_r) && $stable(odd_r))
    else $error("stage 1 lost a held beat");

endmodule
`default_nettype wire

[rtl/y2r_color_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_color_pipe
// BT.601 limited-range color math: a multiply stage, then a sum, round,
// clamp stage that feeds the output register.
// ----------------------------------------------------------------------------
module y2r_color_pipe (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire y2r_pkg::y2r_beat_t        beat,
  output logic                           take,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [y2r_pkg::PIX_W-1:0]      out_blue_first,
  output logic [y2r_pkg::PIX_W-1:0]      out_green_first,
  output logic [y2r_pkg::PIX_W-1:0]      out_red_first,
  output logic [y2r_pkg::PIX_W-1:0]      out_blue_second,
  output logic [y2r_pkg::PIX_W-1:0]      out_green_second,
  output logic [y2r_pkg::PIX_W-1:0]      out_red_second,
  output logic                           out_line_end,
  output logic                           out_frame_end
);
  import y2r_pkg::*;

  function automatic logic [PIX_W-1:0] clamp_px(input logic signed [SUM_W-1:0] v);
    logic [PIX_W-1:0] res;
    if (v[SUM_W-1]) begin
      res = '0;
    end else if (|v[SUM_W-2:FRAC_W+PIX_W]) begin
      res = '1;
    end else begin
      res = v[FRAC_W+PIX_W-1:FRAC_W];
    end
    return res;
  endfunction

  logic signed [SUM_W-1:0] y0;
  logic signed [SUM_W-1:0] y1;
  logic signed [SUM_W-1:0] d;
  logic signed [SUM_W-1:0] e;

  logic                    v2_r;
  logic signed [SUM_W-1:0] c_first_r;
  logic signed [SUM_W-1:0] c_second_r;
  logic signed [SUM_W-1:0] kb_r;
  logic signed [SUM_W-1:0] kgd_r;
  logic signed [SUM_W-1:0] kge_r;
  logic signed [SUM_W-1:0] kr_r;
  logic                    le2_r;
  logic                    fe2_r;

  logic signed [SUM_W-1:0] b0;
  logic signed [SUM_W-1:0] g0;
  logic signed [SUM_W-1:0] r0;
  logic signed [SUM_W-1:0] b1;
  logic signed [SUM_W-1:0] g1;
  logic signed [SUM_W-1:0] r1;

  logic                    out_valid_r;
  logic                    adv3;
  logic                    adv2;

  assign adv3 = !out_valid_r || !out_stall;
  assign adv2 = !v2_r || adv3;
  assign take = adv2;

  assign y0 = $signed({{(SUM_W-PIX_W){1'b0}}, beat.luma_first}) - LUMA_OFS;
  assign y1 = $signed({{(SUM_W-PIX_W){1'b0}}, beat.luma_second}) - LUMA_OFS;
  assign d  = $signed({{(SUM_W-PIX_W){1'b0}}, beat.chroma_blue}) - CHROMA_OFS;
  assign e  = $signed({{(SUM_W-PIX_W){1'b0}}, beat.chroma_red}) - CHROMA_OFS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && beat.valid) begin
      c_first_r  <= y0 * K_Y;
      c_second_r <= y1 * K_Y;
      kb_r       <= d * K_CB_B;
      kgd_r      <= d * K_CB_G;
      kge_r      <= e * K_CR_G;
      kr_r       <= e * K_CR_R;
      le2_r      <= beat.line_end;
      fe2_r      <= beat.frame_end;
    end
  end

  assign b0 = c_first_r + kb_r + ROUND;
  assign g0 = c_first_r - kgd_r - kge_r + ROUND;
  assign r0 = c_first_r + kr_r + ROUND;
  assign b1 = c_second_r + kb_r + ROUND;
  assign g1 = c_second_r - kgd_r - kge_r + ROUND;
  assign r1 = c_second_r + kr_r + ROUND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv3) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      out_blue_first   <= clamp_px(b0);
      out_green_first  <= clamp_px(g0);
      out_red_first    <= clamp_px(r0);
      out_blue_second  <= clamp_px(b1);
      out_green_second <= clamp_px(g1);
      out_red_second   <= clamp_px(r1);
      out_line_end     <= le2_r;
      out_frame_end    <= fe2_r;
    end
  end

  assign out_valid = out_valid_r;

  a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
    beat.valid && take |=> v2_r)
    else $error("stage 1 beat dropped before multiply stage");

  a_mult_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !adv3 |=> v2_r && $stable(kb_r) && $stable(c_first_r))
    else $error("multiply stage lost a held beat");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && adv3 |=> out_valid_r)
    else $error("multiply stage beat not moved to output");

endmodule
`default_nettype wire

[rtl/yuv420_to_rgb32_converter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuv420_to_rgb32_converter
// YCbCr 4:2:0 luma pairs to RGB, BT.601 limited range, with a chroma line
// memory that carries even-line Cb/Cr over to the following odd line.
//
//   channel   ports                     beat
//   in        in_valid / in_stall       one luma pair, Cb/Cr for even lines
//   out       out_valid / out_stall     two RGB pixels, line and frame end
//   cfg       cfg_wr_en / cfg_index     frame_width (0), frame_height (1)
//
// One pair per cycle while out_stall is low; stage 1, multiply, output regs.
// The chroma memory has one write and one read port and is touched once per
// beat. Reset is synchronous; the memory is not cleared, nothing waits on it.
// Stalls back up stage by stage; empty stages keep accepting.
// ----------------------------------------------------------------------------
module yuv420_to_rgb32_converter #(
  parameter int MAX_WIDTH = y2r_pkg::DEFAULT_MAX_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [y2r_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [y2r_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [y2r_pkg::PIX_W-1:0]     in_luma_first,
  input  wire logic [y2r_pkg::PIX_W-1:0]     in_luma_second,
  input  wire logic [y2r_pkg::PIX_W-1:0]     in_chroma_blue,
  input  wire logic [y2r_pkg::PIX_W-1:0]     in_chroma_red,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [y2r_pkg::PIX_W-1:0]          out_blue_first,
  output logic [y2r_pkg::PIX_W-1:0]          out_green_first,
  output logic [y2r_pkg::PIX_W-1:0]          out_red_first,
  output logic [y2r_pkg::PIX_W-1:0]          out_blue_second,
  output logic [y2r_pkg::PIX_W-1:0]          out_green_second,
  output logic [y2r_pkg::PIX_W-1:0]          out_red_second,
  output logic                               out_line_end,
  output logic                               out_frame_end
);
  import y2r_pkg::*;

  y2r_beat_t beat;
  logic      take;

  y2r_chroma_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_store (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_luma_first  (in_luma_first),
    .in_luma_second (in_luma_second),
    .in_chroma_blue (in_chroma_blue),
    .in_chroma_red  (in_chroma_red),
    .take           (take),
    .beat           (beat)
  );

  y2r_color_pipe u_color (
    .clk              (clk),
    .rst_n            (rst_n),
    .beat             (beat),
    .take             (take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_blue_first   (out_blue_first),
    .out_green_first  (out_green_first),
    .out_red_first    (out_red_first),
    .out_blue_second  (out_blue_second),
    .out_green_second (out_green_second),
    .out_red_second   (out_red_second),
    .out_line_end     (out_line_end),
    .out_frame_end    (out_frame_end)
  );

endmodule
`default_nettype wire
